/* design/falru_pkg.sv */
// Shared types and constants for the fully associative LRU tag store.
// Depends on nothing; the interfaces, falru_ctrl, falru_dp and the top import it.
`default_nettype none

package falru_pkg;

  localparam int unsigned X_W   = 16;
  localparam int unsigned Y_W   = 16;
  localparam int unsigned GEN_W = 32;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned KEY_W = X_W + Y_W + GEN_W;

  typedef enum logic [1:0] {
    FUNC_LOOKUP  = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_ADVANCE = 2'd3
  } func_e;

  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [Y_W-1:0]   y;
    logic [X_W-1:0]   x;
  } key_t;

  // Controller to datapath.
  typedef struct packed {
    logic init_wr;  // write the reset rank at the sweep address
    logic accept;   // latch the incoming word, restart the address
    logic scan_rd;  // read key and rank at the sweep address
    logic upd_rd;   // read rank at the sweep address for the recency update
    logic decide;   // latch the chosen slot, restart the address
    logic commit;   // apply the operation and load the result register
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic seq_op;       // incoming word needs a scan (lookup or insert)
    logic addr_last;    // sweep address is at the last entry
    logic need_update;  // recency ranks must be rewritten
    logic out_free;     // result register can take a new word
  } dp_status_t;

endpackage

`default_nettype wire

/* design/falru_req_if.sv */
// Request channel: valid/ready handshake carrying one operation word.
// Depends on falru_pkg.
`default_nettype none

interface falru_req_if
  import falru_pkg::*;
;
  logic             valid;
  logic             ready;
  func_e            func;
  logic [X_W-1:0]   key_x;
  logic [Y_W-1:0]   key_y;
  logic [GEN_W-1:0] key_gen;

  modport source (output valid, func, key_x, key_y, key_gen, input ready);
  modport sink   (input valid, func, key_x, key_y, key_gen, output ready);
endinterface

`default_nettype wire

/* design/falru_rsp_if.sv */
// Response channel: valid/ready handshake carrying one result word.
// Depends on falru_pkg; slot and occupancy widths follow CAPACITY.
`default_nettype none

interface falru_rsp_if
  import falru_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
);
  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned OccW  = $clog2(CAPACITY + 1);

  logic             valid;
  logic             ready;
  logic             hit;
  logic [SlotW-1:0] slot;
  logic             evicted;
  logic [OccW-1:0]  occupancy;
  logic [GEN_W-1:0] generation_now;
  logic [CNT_W-1:0] hits_total;
  logic [CNT_W-1:0] misses_total;

  modport source (output valid, hit, slot, evicted, occupancy, generation_now,
                  hits_total, misses_total, input ready);
  modport sink   (input valid, hit, slot, evicted, occupancy, generation_now,
                  hits_total, misses_total, output ready);
endinterface

`default_nettype wire

/* design/falru_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module falru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* design/falru_ctrl.sv */
// Sequencer for the tag store: init sweep, tag scan, rank update, commit.
// Depends on falru_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module falru_ctrl
  import falru_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctl_cmd_t        cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPD_TAIL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.addr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = status_i.seq_op ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (status_i.addr_last) state_d = ST_SCAN_TAIL;
      end
      ST_SCAN_TAIL: state_d = ST_DECIDE;
      ST_DECIDE: begin
        state_d = status_i.need_update ? ST_UPDATE : ST_DONE;
      end
      ST_UPDATE: begin
        if (status_i.addr_last) state_d = ST_UPD_TAIL;
      end
      ST_UPD_TAIL: state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cmd_o.init_wr  = (state_q == ST_INIT);
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.scan_rd  = (state_q == ST_SCAN);
  assign cmd_o.upd_rd   = (state_q == ST_UPDATE);
  assign cmd_o.decide   = (state_q == ST_DECIDE);
  assign cmd_o.commit   = (state_q == ST_DONE) && status_i.out_free;

endmodule

`default_nettype wire

/* design/falru_dp.sv */
// Datapath: key and rank RAMs, valid bits, scan trackers, counters, result register.
// Depends on falru_pkg and falru_ram; steered by falru_ctrl.
`default_nettype none

module falru_dp
  import falru_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  localparam int unsigned IdxW = $clog2(CAPACITY),
  localparam int unsigned OccW = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctl_cmd_t         cmd_i,
  output dp_status_t            status_o,
  input  wire func_e            in_func_i,
  input  wire key_t             in_key_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic                  out_hit_o,
  output logic [IdxW-1:0]       out_slot_o,
  output logic                  out_evicted_o,
  output logic [OccW-1:0]       out_occupancy_o,
  output logic [GEN_W-1:0]      out_generation_o,
  output logic [CNT_W-1:0]      out_hits_o,
  output logic [CNT_W-1:0]      out_misses_o
);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  // Latched operation word
  func_e func_q;
  key_t  key_q;

  // Sweep address and the read tag, registered alongside the RAM read
  logic [IdxW-1:0] addr_q;
  logic            d1_scan_q, d1_upd_q;
  logic [IdxW-1:0] d1_idx_q;

  // Scan trackers
  logic            found_match_q, found_inv_q;
  logic [IdxW-1:0] match_idx_q, match_rank_q, inv_idx_q, inv_rank_q, lru_idx_q;

  // Decision
  logic [IdxW-1:0] sel_slot_q, old_rank_q;
  logic            hit_q, evict_q, fill_q;
  logic [IdxW-1:0] dec_slot, dec_old;
  logic            dec_fill, dec_evict, need_update;

  // Architectural state
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [OccW-1:0]     occ_q, occ_d;
  logic [GEN_W-1:0]    gen_q, gen_d;
  logic [CNT_W-1:0]    hits_q, hits_d, misses_q, misses_d;

  // Result register
  logic             out_valid_q;
  logic             out_hit_q, out_evicted_q;
  logic [IdxW-1:0]  out_slot_q;
  logic [OccW-1:0]  out_occ_q;
  logic [GEN_W-1:0] out_gen_q;
  logic [CNT_W-1:0] out_hits_q, out_misses_q;

  // RAM ports
  logic [KEY_W-1:0] key_rd_raw;
  key_t             key_rd;
  logic [IdxW-1:0]  rank_rd, new_rank, rank_wr_addr, rank_wr_data;
  logic             key_wr_en, rank_wr_en, entry_valid, seq_func;

  assign key_rd = key_t'(key_rd_raw);
  assign seq_func = (func_q == FUNC_LOOKUP) || (func_q == FUNC_INSERT);
  assign key_wr_en = cmd_i.commit && (func_q == FUNC_INSERT) && !hit_q;

  // Move the touched entry to the top, drop the ones above its old rank
  always_comb begin
    new_rank = rank_rd;
    if (d1_idx_q == sel_slot_q) begin
      new_rank = LastIdx;
    end else if (rank_rd > old_rank_q) begin
      new_rank = rank_rd - IdxW'(1);
    end
  end

  assign rank_wr_en   = cmd_i.init_wr || d1_upd_q;
  assign rank_wr_addr = cmd_i.init_wr ? addr_q : d1_idx_q;
  assign rank_wr_data = cmd_i.init_wr ? addr_q : new_rank;

  falru_ram #(
    .Width (KEY_W),
    .Depth (CAPACITY)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (key_wr_en),
    .wr_addr_i (sel_slot_q),
    .wr_data_i (key_q),
    .rd_en_i   (cmd_i.scan_rd),
    .rd_addr_i (addr_q),
    .rd_data_o (key_rd_raw)
  );

  falru_ram #(
    .Width (IdxW),
    .Depth (CAPACITY)
  ) u_rank_ram (
    .clk_i     (clk_i),
    .wr_en_i   (rank_wr_en),
    .wr_addr_i (rank_wr_addr),
    .wr_data_i (rank_wr_data),
    .rd_en_i   (cmd_i.scan_rd || cmd_i.upd_rd),
    .rd_addr_i (addr_q),
    .rd_data_o (rank_rd)
  );

  assign entry_valid = valid_q[d1_idx_q];

  // Pick the slot: match first; for an insert, then lowest invalid, then the rank-0 entry
  always_comb begin
    dec_slot  = '0;
    dec_old   = '0;
    dec_fill  = 1'b0;
    dec_evict = 1'b0;
    if (found_match_q) begin
      dec_slot = match_idx_q;
      dec_old  = match_rank_q;
    end else if (func_q == FUNC_INSERT) begin
      if (found_inv_q) begin
        dec_slot = inv_idx_q;
        dec_old  = inv_rank_q;
        dec_fill = 1'b1;
      end else begin
        dec_slot  = lru_idx_q;
        dec_evict = 1'b1;
      end
    end
  end

  assign need_update = found_match_q || (func_q == FUNC_INSERT);

  // Commit the operation
  always_comb begin
    valid_d  = valid_q;
    occ_d    = occ_q;
    gen_d    = gen_q;
    hits_d   = hits_q;
    misses_d = misses_q;
    case (func_q)
      FUNC_LOOKUP: begin
        if (hit_q) begin
          if (hits_q != '1) hits_d = hits_q + CNT_W'(1);
        end else begin
          if (misses_q != '1) misses_d = misses_q + CNT_W'(1);
        end
      end
      FUNC_INSERT: begin
        if (!hit_q) valid_d[sel_slot_q] = 1'b1;
        if (fill_q) occ_d = occ_q + OccW'(1);
      end
      FUNC_CLEAR: begin
        valid_d = '0;
        occ_d   = '0;
        gen_d   = gen_q + GEN_W'(1);
      end
      FUNC_ADVANCE: gen_d = gen_q + GEN_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      d1_scan_q   <= 1'b0;
      d1_upd_q    <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      gen_q       <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      d1_scan_q <= cmd_i.scan_rd;
      d1_upd_q  <= cmd_i.upd_rd;
      if (cmd_i.accept || cmd_i.decide) begin
        addr_q <= '0;
      end else if (cmd_i.init_wr || cmd_i.scan_rd || cmd_i.upd_rd) begin
        addr_q <= addr_q + IdxW'(1);
      end
      if (cmd_i.commit) begin
        valid_q     <= valid_d;
        occ_q       <= occ_d;
        gen_q       <= gen_d;
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and tracker registers, without reset; accept clears the match and invalid flags
  always_ff @(posedge clk_i) begin
    d1_idx_q <= addr_q;
    if (cmd_i.accept) begin
      func_q        <= in_func_i;
      key_q         <= in_key_i;
      found_match_q <= 1'b0;
      found_inv_q   <= 1'b0;
    end
    if (d1_scan_q) begin
      if (entry_valid && (key_rd == key_q) && !found_match_q) begin
        found_match_q <= 1'b1;
        match_idx_q   <= d1_idx_q;
        match_rank_q  <= rank_rd;
      end
      if (!entry_valid && !found_inv_q) begin
        found_inv_q <= 1'b1;
        inv_idx_q   <= d1_idx_q;
        inv_rank_q  <= rank_rd;
      end
      if (rank_rd == '0) begin
        lru_idx_q <= d1_idx_q;
      end
    end
    if (cmd_i.decide) begin
      sel_slot_q <= dec_slot;
      old_rank_q <= dec_old;
      hit_q      <= found_match_q;
      fill_q     <= dec_fill;
      evict_q    <= dec_evict;
    end
    if (cmd_i.commit) begin
      out_hit_q     <= seq_func && hit_q;
      out_slot_q    <= seq_func ? sel_slot_q : '0;
      out_evicted_q <= (func_q == FUNC_INSERT) && evict_q;
      out_occ_q     <= occ_d;
      out_gen_q     <= gen_d;
      out_hits_q    <= hits_d;
      out_misses_q  <= misses_d;
    end
  end

  assign status_o.seq_op      = (in_func_i == FUNC_LOOKUP) || (in_func_i == FUNC_INSERT);
  assign status_o.addr_last   = (addr_q == LastIdx);
  assign status_o.need_update = need_update;
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_slot_o       = out_slot_q;
  assign out_evicted_o    = out_evicted_q;
  assign out_occupancy_o  = out_occ_q;
  assign out_generation_o = out_gen_q;
  assign out_hits_o       = out_hits_q;
  assign out_misses_o     = out_misses_q;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == occ_q)
    else $error("occupancy count differs from the number of valid entries");

  a_fill_target_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (func_q == FUNC_INSERT) && fill_q) |-> !valid_q[sel_slot_q])
    else $error("fill chose an entry that is already valid");

  a_evict_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (func_q == FUNC_INSERT) && evict_q) |-> (&valid_q))
    else $error("eviction while an invalid entry exists");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_occ_q)))
    else $error("stalled result word changed");

endmodule

`default_nettype wire

/* design/fully_assoc_lru_tag_store_top.sv */
// Top level of the fully associative LRU tag store; depends on falru_pkg, the interfaces,
// falru_ctrl, falru_dp and falru_ram.
// A lookup hit or insert scans, decides, updates ranks and commits; a lookup miss skips the
// rank update; clear/advance go straight to commit. A word is taken only after the one before
// commits; scan and rank sweeps step one entry a cycle. Reset: valid bits and counters clear
// at once; a sweep then loads the rank RAM with index order, with ready low until it ends.
`default_nettype none

module fully_assoc_lru_tag_store_top
  import falru_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  falru_req_if.sink   in_req_i,
  falru_rsp_if.source out_rsp_o
);

  // Control and status between the sequencer and the datapath
  ctl_cmd_t   cmd;
  dp_status_t status;

  // Each input word is one operation; the sequencer holds ready low
  // from acceptance until the result word is loaded.
  falru_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_req_i.valid),
    .in_ready_o (in_req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath owns the stores, the counters and the result register, so a
  // finished word can wait for the sink while a new word is accepted.
  falru_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_func_i        (in_req_i.func),
    .in_key_i         ({in_req_i.key_gen, in_req_i.key_y, in_req_i.key_x}),
    .out_valid_o      (out_rsp_o.valid),
    .out_ready_i      (out_rsp_o.ready),
    .out_hit_o        (out_rsp_o.hit),
    .out_slot_o       (out_rsp_o.slot),
    .out_evicted_o    (out_rsp_o.evicted),
    .out_occupancy_o  (out_rsp_o.occupancy),
    .out_generation_o (out_rsp_o.generation_now),
    .out_hits_o       (out_rsp_o.hits_total),
    .out_misses_o     (out_rsp_o.misses_total)
  );

endmodule

`default_nettype wire
